// ===== hdl/nps_pkg.sv =====
// shared widths, defaults and item types for the priority scheduler
// no dependencies
package nps_pkg;

   localparam int ID_W   = 8;
   localparam int PRIO_W = 3;
   localparam int TIME_W = 16;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_NUM_LEVELS  = 4;

   localparam logic [TIME_W-1:0] CUTOFF_RESET = 16'd100;
   localparam logic [TIME_W-1:0] TIME_MAX     = '1;

   typedef enum logic {
      CMD_ARRIVAL = 1'b0,
      CMD_TICK    = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] service;
      logic [TIME_W-1:0] stamp;
   } job_type;

   // classified item handed from front to back
   typedef struct packed {
      cmd_type           kind;
      logic [PRIO_W-1:0] level;
      job_type           job;
   } work_type;

   typedef struct packed {
      logic              slot_busy;
      logic [ID_W-1:0]   running_id;
      logic              job_finished;
      logic [PRIO_W-1:0] finished_priority;
      logic [TIME_W-1:0] start_tick;
      logic [TIME_W-1:0] end_tick;
      logic [TIME_W-1:0] job_arrival;
      logic              schedule_done;
      logic              queue_overflow;
   } result_type;

endpackage

// ===== hdl/nps_req_if.sv =====
// request channel: arrivals and ticks with valid/ready handshake
// depends on nps_pkg
interface nps_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [nps_pkg::ID_W-1:0]    job_id;
   logic [nps_pkg::PRIO_W-1:0]  priority_level;
   logic [nps_pkg::TIME_W-1:0]  service_time;
   logic [nps_pkg::TIME_W-1:0]  arrival_stamp;

   modport source (
      output valid, command, job_id, priority_level, service_time, arrival_stamp,
      input  ready
   );
   modport sink (
      input  valid, command, job_id, priority_level, service_time, arrival_stamp,
      output ready
   );
endinterface

// ===== hdl/nps_rsp_if.sv =====
// response channel: one item per tick with valid/ready handshake
// depends on nps_pkg
interface nps_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        slot_busy;
   logic [nps_pkg::ID_W-1:0]    running_id;
   logic                        job_finished;
   logic [nps_pkg::PRIO_W-1:0]  finished_priority;
   logic [nps_pkg::TIME_W-1:0]  start_tick;
   logic [nps_pkg::TIME_W-1:0]  end_tick;
   logic [nps_pkg::TIME_W-1:0]  job_arrival;
   logic                        schedule_done;
   logic                        queue_overflow;

   modport source (
      output valid, slot_busy, running_id, job_finished, finished_priority,
             start_tick, end_tick, job_arrival, schedule_done, queue_overflow,
      input  ready
   );
   modport sink (
      input  valid, slot_busy, running_id, job_finished, finished_priority,
             start_tick, end_tick, job_arrival, schedule_done, queue_overflow,
      output ready
   );
endinterface

// ===== hdl/nps_front.sv =====
// front end: accepts request items, drops bad priorities, queues the rest
// depends on nps_pkg and nps_req_if
module nps_front #(
   parameter int NUM_LEVELS = nps_pkg::DEFAULT_NUM_LEVELS
) (
   input  logic              clock,
   input  logic              reset,
   nps_req_if.sink           req_ch,
   output logic              work_valid,
   input  logic              work_ready,
   output nps_pkg::work_type work_item
);
   import nps_pkg::*;

   localparam logic [PRIO_W:0] MAX_PRIO = (PRIO_W+1)'(NUM_LEVELS);

   work_type   fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   work_type   incoming;
   logic       keep;
   logic       push;
   logic       pop;

   always_comb begin
      incoming.kind        = cmd_type'(req_ch.command);
      incoming.level       = req_ch.priority_level - PRIO_W'(1);
      incoming.job.id      = req_ch.job_id;
      incoming.job.service = req_ch.service_time;
      incoming.job.stamp   = req_ch.arrival_stamp;
      keep = (incoming.kind == CMD_TICK)
          || ((req_ch.priority_level != '0) && ({1'b0, req_ch.priority_level} <= MAX_PRIO));
   end

   assign req_ch.ready = (count_ff != 2'd2);
   assign work_valid   = (count_ff != 2'd0);
   assign work_item    = fifo_ff[rd_ptr_ff];

   assign push = req_ch.valid && req_ch.ready && keep;
   assign pop  = work_valid && work_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

// ===== hdl/nps_back.sv =====
// back end: level queues in memory, run slot, tick counter, response register
// depends on nps_pkg and nps_rsp_if
module nps_back #(
   parameter int QUEUE_DEPTH = nps_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int NUM_LEVELS  = nps_pkg::DEFAULT_NUM_LEVELS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [nps_pkg::TIME_W-1:0] csr_write_data,
   input  logic                       work_valid,
   output logic                       work_ready,
   input  nps_pkg::work_type          work_item,
   nps_rsp_if.source                  rsp_ch
);
   import nps_pkg::*;

   localparam int LVL_W     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W:0]    POS_WRAP = (CNT_W+1)'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [ADDR_W-1:0] ROW_SPAN = ADDR_W'(QUEUE_DEPTH);

   typedef enum logic {
      ST_RUN,
      ST_FETCH
   } state_type;

   state_type         state_ff, state_in;
   logic [TIME_W-1:0] cutoff_ff, cutoff_in;
   logic [TIME_W-1:0] tick_ff, tick_in;
   logic              slot_valid_ff, slot_valid_in;
   job_type           slot_job_ff, slot_job_in;
   logic [PRIO_W-1:0] slot_level_ff, slot_level_in;
   logic [TIME_W-1:0] slot_start_ff, slot_start_in;
   logic [TIME_W-1:0] slot_elapsed_ff, slot_elapsed_in;
   logic [PTR_W-1:0]  head_ff [NUM_LEVELS];
   logic [PTR_W-1:0]  head_in [NUM_LEVELS];
   logic [CNT_W-1:0]  count_ff [NUM_LEVELS];
   logic [CNT_W-1:0]  count_in [NUM_LEVELS];
   logic              overflow_ff, overflow_in;
   logic [PRIO_W-1:0] fetch_level_ff, fetch_level_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;

   job_type           queue_mem [MEM_DEPTH];
   job_type           rd_data_ff;
   logic              mem_we;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ADDR_W-1:0] mem_raddr;

   logic              fire;
   logic              is_tick;
   logic              past_cutoff;
   logic              out_free;
   logic              start_job;
   logic              emit;
   logic [LVL_W-1:0]  arr_lv;
   logic [LVL_W-1:0]  pick_lv;
   logic              any_ready;
   logic [CNT_W:0]    pos_sum;
   logic [PTR_W-1:0]  wr_ptr;

   logic              cur_busy;
   job_type           cur_job;
   logic [PRIO_W-1:0] cur_level;
   logic [TIME_W-1:0] cur_start;
   logic [TIME_W-1:0] cur_elapsed;
   logic [TIME_W-1:0] elapsed_next;
   logic              fin;
   result_type        result;

   // lowest-numbered non-empty level (priority 1 first)
   always_comb begin
      any_ready = 1'b0;
      pick_lv   = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            any_ready = 1'b1;
            pick_lv   = LVL_W'(i);
         end
      end
   end

   always_comb begin
      is_tick     = (work_item.kind == CMD_TICK);
      arr_lv      = work_item.level[LVL_W-1:0];
      past_cutoff = (tick_ff >= cutoff_ff);
      out_free    = !rsp_valid_ff || rsp_ch.ready;
      work_ready  = (state_ff == ST_RUN) && (!is_tick || out_free);
      fire        = work_valid && work_ready;
      start_job   = fire && is_tick && !slot_valid_ff && !past_cutoff && any_ready;
      emit        = (fire && is_tick && !start_job) || ((state_ff == ST_FETCH) && out_free);

      pos_sum = (CNT_W+1)'(head_ff[arr_lv]) + (CNT_W+1)'(count_ff[arr_lv]);
      if (pos_sum >= POS_WRAP) begin
         pos_sum = pos_sum - POS_WRAP;
      end
      wr_ptr    = pos_sum[PTR_W-1:0];
      mem_waddr = ADDR_W'(arr_lv) * ROW_SPAN + ADDR_W'(wr_ptr);
      mem_raddr = ADDR_W'(pick_lv) * ROW_SPAN + ADDR_W'(head_ff[pick_lv]);
   end

   // job seen this tick: the slot, or the one just read from memory
   always_comb begin
      if (state_ff == ST_FETCH) begin
         cur_busy    = 1'b1;
         cur_job     = rd_data_ff;
         cur_level   = fetch_level_ff;
         cur_start   = tick_ff;
         cur_elapsed = '0;
      end else begin
         cur_busy    = slot_valid_ff;
         cur_job     = slot_job_ff;
         cur_level   = slot_level_ff;
         cur_start   = slot_start_ff;
         cur_elapsed = slot_elapsed_ff;
      end
      elapsed_next = (cur_elapsed != TIME_MAX) ? cur_elapsed + TIME_W'(1) : cur_elapsed;
      fin          = cur_busy && (elapsed_next >= cur_job.service);

      result                = '0;
      result.end_tick       = tick_ff;
      result.queue_overflow = overflow_ff;
      result.schedule_done  = past_cutoff && !(cur_busy && !fin);
      if (cur_busy) begin
         result.slot_busy         = 1'b1;
         result.running_id        = cur_job.id;
         result.job_finished      = fin;
         result.finished_priority = cur_level;
         result.start_tick        = cur_start;
         result.job_arrival       = cur_job.stamp;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cutoff_in       = cutoff_ff;
      tick_in         = tick_ff;
      slot_valid_in   = slot_valid_ff;
      slot_job_in     = slot_job_ff;
      slot_level_in   = slot_level_ff;
      slot_start_in   = slot_start_ff;
      slot_elapsed_in = slot_elapsed_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      overflow_in     = overflow_ff;
      fetch_level_in  = fetch_level_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      mem_we          = 1'b0;
      mem_re          = 1'b0;

      if (csr_write_enable) begin
         cutoff_in = csr_write_data;
      end

      if (fire && !is_tick) begin
         if (count_ff[arr_lv] == CNT_FULL) begin
            overflow_in = 1'b1;
         end else begin
            mem_we           = 1'b1;
            count_in[arr_lv] = count_ff[arr_lv] + CNT_W'(1);
         end
      end

      // discard waiting jobs from the cutoff on
      if (fire && is_tick && past_cutoff) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_in[i]  = '0;
            count_in[i] = '0;
         end
      end

      if (start_job) begin
         head_in[pick_lv]  = (head_ff[pick_lv] == PTR_LAST) ? '0
                                                             : head_ff[pick_lv] + PTR_W'(1);
         count_in[pick_lv] = count_ff[pick_lv] - CNT_W'(1);
         fetch_level_in    = PRIO_W'(pick_lv) + PRIO_W'(1);
         mem_re            = 1'b1;
         state_in          = ST_FETCH;
      end

      if (emit) begin
         slot_valid_in   = cur_busy && !fin;
         slot_job_in     = cur_job;
         slot_level_in   = cur_level;
         slot_start_in   = cur_start;
         slot_elapsed_in = elapsed_next;
         tick_in         = (tick_ff != TIME_MAX) ? tick_ff + TIME_W'(1) : tick_ff;
         state_in        = ST_RUN;
         rsp_valid_in    = 1'b1;
         rsp_data_in     = result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_RUN;
         cutoff_ff       <= CUTOFF_RESET;
         tick_ff         <= '0;
         slot_valid_ff   <= 1'b0;
         slot_elapsed_ff <= '0;
         overflow_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         cutoff_ff       <= cutoff_in;
         tick_ff         <= tick_in;
         slot_valid_ff   <= slot_valid_in;
         slot_elapsed_ff <= slot_elapsed_in;
         overflow_ff     <= overflow_in;
         rsp_valid_ff    <= rsp_valid_in;
         head_ff         <= head_in;
         count_ff        <= count_in;
      end
      slot_job_ff    <= slot_job_in;
      slot_level_ff  <= slot_level_in;
      slot_start_ff  <= slot_start_in;
      fetch_level_ff <= fetch_level_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // level queue storage
   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[mem_waddr] <= work_item.job;
      end
      if (mem_re) begin
         rd_data_ff <= queue_mem[mem_raddr];
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.slot_busy         = rsp_data_ff.slot_busy;
   assign rsp_ch.running_id        = rsp_data_ff.running_id;
   assign rsp_ch.job_finished      = rsp_data_ff.job_finished;
   assign rsp_ch.finished_priority = rsp_data_ff.finished_priority;
   assign rsp_ch.start_tick        = rsp_data_ff.start_tick;
   assign rsp_ch.end_tick          = rsp_data_ff.end_tick;
   assign rsp_ch.job_arrival       = rsp_data_ff.job_arrival;
   assign rsp_ch.schedule_done     = rsp_data_ff.schedule_done;
   assign rsp_ch.queue_overflow    = rsp_data_ff.queue_overflow;

endmodule

// ===== hdl/nonpreemptive_priority_scheduler_unit.sv =====
// Non-preemptive multilevel priority scheduler, top level.
// req_ch carries items: a job arrival (id, priority 1..NUM_LEVELS, service
// time, arrival stamp) or one time tick. Arrivals go to a per-level FIFO of
// QUEUE_DEPTH entries; bad priorities are dropped, a full FIFO drops the item
// and sets the sticky overflow flag. Every tick yields one rsp_ch item telling
// what ran, whether it finished, and whether the cutoff is reached with nothing running.
// csr_write_enable/csr_write_data load the cutoff tick (reset value 100).
// Each accepted item is registered in the front queue, and a tick's response
// in the back-end response register. A tick that starts a new job first reads
// the level memory in a fetch state before responding; otherwise the back
// end takes one item per cycle, ticks only while the response register is free.
// A stalled rsp_ch holds its item; arrivals ahead of the first waiting tick
// still drain, then the two-entry front queue fills and req_ch.ready drops
// until the response register frees up.
// Reset is synchronous: queues, slot, tick counter and overflow flag clear,
// the level memory needs no clearing pass.
// depends on nps_pkg, nps_req_if, nps_rsp_if, nps_front, nps_back
module nonpreemptive_priority_scheduler_unit #(
   parameter int QUEUE_DEPTH = nps_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int NUM_LEVELS  = nps_pkg::DEFAULT_NUM_LEVELS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [nps_pkg::TIME_W-1:0] csr_write_data,
   nps_req_if.sink                    req_ch,
   nps_rsp_if.source                  rsp_ch
);
   import nps_pkg::*;

   logic     work_valid;
   logic     work_ready;
   work_type work_item;

   nps_front #(
      .NUM_LEVELS (NUM_LEVELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .work_valid (work_valid),
      .work_ready (work_ready),
      .work_item  (work_item)
   );

   nps_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .NUM_LEVELS  (NUM_LEVELS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .work_valid       (work_valid),
      .work_ready       (work_ready),
      .work_item        (work_item),
      .rsp_ch           (rsp_ch)
   );

endmodule
